### rtl/core/hnu_pkg.sv
package hnu_pkg;

	localparam int DIM_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam int HEIGHT_W   = 16;
	localparam int DIFF_W     = 17;
	localparam int MAG_W      = 16;
	localparam int PROD_W     = 32;
	localparam int SUM_W      = 34;
	localparam int RAD_W      = 50;
	localparam int ROOT_W     = 25;
	localparam int NUM_W      = 41;
	localparam int DEN_W      = 26;
	localparam int QUO_W      = 17;
	localparam int REM_W      = DEN_W + QUO_W - 1;
	localparam int STEP_W     = 5;
	localparam int COMP_W     = 16;
	localparam int NY_W       = 15;

	localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(ROOT_W);
	localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(QUO_W);

	localparam logic [CFG_DATA_W-1:0] GRID_RESET = 7'd64;
	localparam logic [MAG_W-1:0]      DY_MAG     = 16'd512;
	localparam logic [SUM_W-1:0]      DY_SQ      = 34'd262144;
	localparam logic [QUO_W-1:0]      Q_MAX      = 17'd32767;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_NORMAL = 1'b1
	} op_t;

	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} arith_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} arith_sts_t;

endpackage

### rtl/core/hnu_store.sv
module hnu_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [hnu_pkg::HEIGHT_W-1:0] wdata,
	input  logic [AW-1:0]                raddr,
	output logic [hnu_pkg::HEIGHT_W-1:0] rdata
);

	logic [hnu_pkg::HEIGHT_W-1:0] mem [DEPTH];
	logic [hnu_pkg::HEIGHT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/hnu_arith.sv
module hnu_arith (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hnu_pkg::arith_cmd_t        cmd,
	input  logic [hnu_pkg::RAD_W-1:0]  radicand,
	input  logic [hnu_pkg::NUM_W-1:0]  dividend,
	input  logic [hnu_pkg::DEN_W-1:0]  divisor,
	output hnu_pkg::arith_sts_t        sts,
	output logic [hnu_pkg::ROOT_W-1:0] result
);

	logic                         mode_q;
	logic                         busy_q;
	logic                         done_q;
	logic [hnu_pkg::STEP_W-1:0]   cnt_q;
	logic [hnu_pkg::REM_W-1:0]    rem_q;
	logic [hnu_pkg::RAD_W-1:0]    aux_q;
	logic [hnu_pkg::ROOT_W-1:0]   res_q;
	logic [hnu_pkg::REM_W-1:0]    op_a;
	logic [hnu_pkg::REM_W-1:0]    op_b;
	logic [hnu_pkg::REM_W-1:0]    diff;
	logic                         ge;

	// Square root brings down two radicand bits per step; division shifts the divisor right.
	always_comb begin
		if (mode_q) begin
			op_a = {rem_q[hnu_pkg::REM_W-3:0], aux_q[hnu_pkg::RAD_W-1 -: 2]};
			op_b = hnu_pkg::REM_W'({res_q, 2'b01});
		end else begin
			op_a = rem_q;
			op_b = aux_q[hnu_pkg::REM_W-1:0];
		end
		diff = op_a - op_b;
		ge   = (op_a >= op_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			mode_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == hnu_pkg::STEP_W'(1));
			if (cmd.start && !busy_q) begin
				busy_q <= 1'b1;
				mode_q <= cmd.sqrt_mode;
				cnt_q  <= cmd.sqrt_mode ? hnu_pkg::SQRT_STEPS : hnu_pkg::DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == hnu_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && !busy_q) begin
			res_q <= '0;
			if (cmd.sqrt_mode) begin
				rem_q <= '0;
				aux_q <= radicand;
			end else begin
				rem_q <= hnu_pkg::REM_W'(dividend);
				aux_q <= hnu_pkg::RAD_W'({divisor, {(hnu_pkg::QUO_W-1){1'b0}}});
			end
		end else if (busy_q) begin
			res_q <= {res_q[hnu_pkg::ROOT_W-2:0], ge};
			rem_q <= ge ? diff : op_a;
			if (mode_q) begin
				aux_q <= {aux_q[hnu_pkg::RAD_W-3:0], 2'b00};
			end else begin
				aux_q <= {1'b0, aux_q[hnu_pkg::RAD_W-1:1]};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign result   = res_q;

endmodule

### rtl/core/heightmap_normal_unit.sv
// A load beat (operation 0) writes one Q8.8 height and gives no result; loads outside the
// configured grid are dropped. A normal request (operation 1) goes from acceptance to result
// in steps: it reads the four clamped neighbors from the height memory through its single
// read port, forms the squared length with one 16x16 multiplier, then uses a shared
// subtract-and-compare unit that yields one bit per cycle for the square root and for each
// of the three divisions (a start and a finish step around 25 or 17 bit steps), and last
// loads the result register. The last step stretches while an earlier result is still
// waiting to be taken. in_ready is high only while the block is idle. Height entries must
// be loaded before a request reads them.
module heightmap_normal_unit #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           operation,
	input  logic [5:0]                     col,
	input  logic [5:0]                     row,
	input  logic signed [15:0]             height_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [15:0]             normal_x,
	output logic [14:0]                    normal_y,
	output logic signed [15:0]             normal_z,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hnu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hnu_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW    = $clog2(MAX_COLS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_READ   = 6'b000010,
		ST_SQUARE = 6'b000100,
		ST_SQRT   = 6'b001000,
		ST_DIV    = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	state_t                            state_q;
	logic [hnu_pkg::CFG_DATA_W-1:0]    gw_q;
	logic [hnu_pkg::CFG_DATA_W-1:0]    gh_q;
	logic [hnu_pkg::DIM_W-1:0]         w_eff;
	logic [hnu_pkg::DIM_W-1:0]         h_eff;
	logic [hnu_pkg::DIM_W-1:0]         w_m1;
	logic [hnu_pkg::DIM_W-1:0]         h_m1;
	logic [hnu_pkg::DIM_W-1:0]         col_ext;
	logic [hnu_pkg::DIM_W-1:0]         row_ext;
	logic [hnu_pkg::DIM_W-1:0]         c_clamp;
	logic [hnu_pkg::DIM_W-1:0]         r_clamp;
	logic                              in_fire;
	logic                              in_grid;
	logic                              we;
	logic [AW-1:0]                     waddr;
	logic [AW-1:0]                     raddr;
	logic [hnu_pkg::HEIGHT_W-1:0]      rdata;

	logic [CW-1:0]                     c_q;
	logic [RW-1:0]                     r_q;
	logic [CW-1:0]                     wm1_q;
	logic [RW-1:0]                     hm1_q;
	logic [CW-1:0]                     rd_c;
	logic [RW-1:0]                     rd_r;
	logic [2:0]                        rd_cnt_q;
	logic [1:0]                        sq_cnt_q;
	logic [1:0]                        div_cnt_q;
	logic                              started_q;
	logic                              out_valid_q;
	logic [hnu_pkg::HEIGHT_W-1:0]      h_q [4];
	logic [hnu_pkg::DIFF_W-1:0]        dx;
	logic [hnu_pkg::DIFF_W-1:0]        dz;
	logic [hnu_pkg::DIFF_W-1:0]        dx_neg;
	logic [hnu_pkg::DIFF_W-1:0]        dz_neg;
	logic                              sx_q;
	logic                              sz_q;
	logic [hnu_pkg::MAG_W-1:0]         mx_q;
	logic [hnu_pkg::MAG_W-1:0]         mz_q;
	logic [hnu_pkg::MAG_W-1:0]         mul_op;
	logic [hnu_pkg::PROD_W-1:0]        prod_q;
	logic [hnu_pkg::SUM_W-1:0]         acc_q;
	logic [hnu_pkg::ROOT_W-1:0]        len_q;
	logic [hnu_pkg::MAG_W-1:0]         div_mag;
	logic                              div_neg;
	logic [hnu_pkg::NY_W-1:0]          q_sat;
	logic [hnu_pkg::COMP_W-1:0]        q_signed;
	logic [hnu_pkg::COMP_W-1:0]        cx_q;
	logic [hnu_pkg::NY_W-1:0]          cy_q;
	logic [hnu_pkg::COMP_W-1:0]        cz_q;
	logic [hnu_pkg::COMP_W-1:0]        nx_q;
	logic [hnu_pkg::NY_W-1:0]          ny_q;
	logic [hnu_pkg::COMP_W-1:0]        nz_q;

	hnu_pkg::arith_cmd_t               arith_cmd;
	hnu_pkg::arith_sts_t               arith_sts;
	logic [hnu_pkg::RAD_W-1:0]         radicand;
	logic [hnu_pkg::NUM_W-1:0]         dividend;
	logic [hnu_pkg::DEN_W-1:0]         divisor;
	logic [hnu_pkg::ROOT_W-1:0]        arith_res;

	// Register writes.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= hnu_pkg::GRID_RESET;
			gh_q <= hnu_pkg::GRID_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				hnu_pkg::REG_GRID_WIDTH:  gw_q <= cfg_data;
				hnu_pkg::REG_GRID_HEIGHT: gh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (gw_q == '0) begin
			w_eff = hnu_pkg::DIM_W'(1);
		end else if (hnu_pkg::DIM_W'(gw_q) > hnu_pkg::DIM_W'(MAX_COLS)) begin
			w_eff = hnu_pkg::DIM_W'(MAX_COLS);
		end else begin
			w_eff = hnu_pkg::DIM_W'(gw_q);
		end
		if (gh_q == '0) begin
			h_eff = hnu_pkg::DIM_W'(1);
		end else if (hnu_pkg::DIM_W'(gh_q) > hnu_pkg::DIM_W'(MAX_ROWS)) begin
			h_eff = hnu_pkg::DIM_W'(MAX_ROWS);
		end else begin
			h_eff = hnu_pkg::DIM_W'(gh_q);
		end
		w_m1    = w_eff - 1'b1;
		h_m1    = h_eff - 1'b1;
		col_ext = hnu_pkg::DIM_W'(col);
		row_ext = hnu_pkg::DIM_W'(row);
		c_clamp = (col_ext < w_eff) ? col_ext : w_m1;
		r_clamp = (row_ext < h_eff) ? row_ext : h_m1;
		in_grid = (col_ext < w_eff) && (row_ext < h_eff);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign we       = in_fire && (operation == hnu_pkg::OP_LOAD) && in_grid;
	assign waddr    = AW'(row_ext[RW-1:0]) * AW'(MAX_COLS) + AW'(col_ext[CW-1:0]);

	// Neighbor order: left, right, north, south.
	always_comb begin
		case (rd_cnt_q[1:0])
			2'd0: begin
				rd_c = (c_q == '0) ? c_q : c_q - 1'b1;
				rd_r = r_q;
			end
			2'd1: begin
				rd_c = (c_q == wm1_q) ? c_q : c_q + 1'b1;
				rd_r = r_q;
			end
			2'd2: begin
				rd_c = c_q;
				rd_r = (r_q == '0) ? r_q : r_q - 1'b1;
			end
			default: begin
				rd_c = c_q;
				rd_r = (r_q == hm1_q) ? r_q : r_q + 1'b1;
			end
		endcase
	end

	assign raddr = AW'(rd_r) * AW'(MAX_COLS) + AW'(rd_c);

	hnu_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(height_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign dx     = {h_q[0][hnu_pkg::HEIGHT_W-1], h_q[0]} - {h_q[1][hnu_pkg::HEIGHT_W-1], h_q[1]};
	assign dz     = {h_q[2][hnu_pkg::HEIGHT_W-1], h_q[2]} - {h_q[3][hnu_pkg::HEIGHT_W-1], h_q[3]};
	assign dx_neg = -dx;
	assign dz_neg = -dz;
	assign mul_op = (sq_cnt_q == 2'd1) ? mx_q : mz_q;

	always_comb begin
		case (div_cnt_q)
			2'd0: begin
				div_mag = mx_q;
				div_neg = sx_q;
			end
			2'd1: begin
				div_mag = hnu_pkg::DY_MAG;
				div_neg = 1'b0;
			end
			default: begin
				div_mag = mz_q;
				div_neg = sz_q;
			end
		endcase
	end

	assign radicand = {acc_q, 16'b0};
	assign dividend = hnu_pkg::NUM_W'({div_mag, 24'b0}) + hnu_pkg::NUM_W'(len_q);
	assign divisor  = {len_q, 1'b0};

	assign arith_cmd.start     = ((state_q == ST_SQRT) || (state_q == ST_DIV)) && !started_q
		&& !arith_sts.busy;
	assign arith_cmd.sqrt_mode = (state_q == ST_SQRT);

	hnu_arith u_arith (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (arith_cmd),
		.radicand(radicand),
		.dividend(dividend),
		.divisor (divisor),
		.sts     (arith_sts),
		.result  (arith_res)
	);

	assign q_sat    = (arith_res[hnu_pkg::QUO_W-1:0] > hnu_pkg::Q_MAX) ?
		hnu_pkg::Q_MAX[hnu_pkg::NY_W-1:0] : arith_res[hnu_pkg::NY_W-1:0];
	assign q_signed = div_neg ? -hnu_pkg::COMP_W'(q_sat) : hnu_pkg::COMP_W'(q_sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_cnt_q    <= '0;
			sq_cnt_q    <= '0;
			div_cnt_q   <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire && (operation == hnu_pkg::OP_NORMAL)) begin
						state_q  <= ST_READ;
						rd_cnt_q <= '0;
					end
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == 3'd4) begin
						state_q  <= ST_SQUARE;
						sq_cnt_q <= '0;
					end
				end
				ST_SQUARE: begin
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (sq_cnt_q == 2'd3) begin
						state_q   <= ST_SQRT;
						started_q <= 1'b0;
					end
				end
				ST_SQRT: begin
					if (arith_sts.done) begin
						state_q   <= ST_DIV;
						div_cnt_q <= '0;
						started_q <= 1'b0;
					end else if (arith_cmd.start) begin
						started_q <= 1'b1;
					end
				end
				ST_DIV: begin
					if (arith_sts.done) begin
						started_q <= 1'b0;
						if (div_cnt_q == 2'd2) begin
							state_q <= ST_OUT;
						end else begin
							div_cnt_q <= div_cnt_q + 1'b1;
						end
					end else if (arith_cmd.start) begin
						started_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			c_q   <= c_clamp[CW-1:0];
			r_q   <= r_clamp[RW-1:0];
			wm1_q <= w_m1[CW-1:0];
			hm1_q <= h_m1[RW-1:0];
		end
		if ((state_q == ST_READ) && (rd_cnt_q != '0)) begin
			h_q[2'(rd_cnt_q - 1'b1)] <= rdata;
		end
		if (state_q == ST_SQUARE) begin
			case (sq_cnt_q)
				2'd0: begin
					sx_q  <= dx[hnu_pkg::DIFF_W-1];
					sz_q  <= dz[hnu_pkg::DIFF_W-1];
					mx_q  <= dx[hnu_pkg::DIFF_W-1] ? dx_neg[hnu_pkg::MAG_W-1:0] :
						dx[hnu_pkg::MAG_W-1:0];
					mz_q  <= dz[hnu_pkg::DIFF_W-1] ? dz_neg[hnu_pkg::MAG_W-1:0] :
						dz[hnu_pkg::MAG_W-1:0];
					acc_q <= hnu_pkg::DY_SQ;
				end
				2'd1: begin
					prod_q <= mul_op * mul_op;
				end
				2'd2: begin
					prod_q <= mul_op * mul_op;
					acc_q  <= acc_q + hnu_pkg::SUM_W'(prod_q);
				end
				default: begin
					acc_q <= acc_q + hnu_pkg::SUM_W'(prod_q);
				end
			endcase
		end
		if ((state_q == ST_SQRT) && arith_sts.done) begin
			len_q <= arith_res;
		end
		if ((state_q == ST_DIV) && arith_sts.done) begin
			case (div_cnt_q)
				2'd0:    cx_q <= q_signed;
				2'd1:    cy_q <= q_sat;
				default: cz_q <= q_signed;
			endcase
		end
		if ((state_q == ST_OUT) && (!out_valid_q || out_ready)) begin
			nx_q <= cx_q;
			ny_q <= cy_q;
			nz_q <= cz_q;
		end
	end

	assign out_valid = out_valid_q;
	assign normal_x  = nx_q;
	assign normal_y  = ny_q;
	assign normal_z  = nz_q;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int STORE_COLS = 64;
	localparam int STORE_CELLS = 4096;
	localparam int ITEM_TARGET = 1700;
	localparam int SETTLE_CYCLES = 120;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic signed [15:0] nx;
		logic [14:0]        ny;
		logic signed [15:0] nz;
	} normal_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BUSY} rx_mode_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic                           operation;
	logic [5:0]                     col;
	logic [5:0]                     row;
	logic signed [15:0]             height_value;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic signed [15:0]             normal_x;
	logic [14:0]                    normal_y;
	logic signed [15:0]             normal_z;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [hnu_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [hnu_pkg::CFG_DATA_W-1:0] cfg_data;

	logic [15:0]      height_mem [0:STORE_CELLS-1];
	bit               height_known [0:STORE_CELLS-1];
	logic [6:0]       grid_w_cfg = 7'd64;
	logic [6:0]       grid_h_cfg = 7'd64;
	normal_t          pending_normals [$];
	int               items_sent = 0;
	int               burst_left = 0;
	int               mismatches = 0;
	int               cycle_count = 0;
	rx_mode_t         rx_mode = RX_OPEN;
	int               rx_left = 0;

	heightmap_normal_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.col          (col),
		.row          (row),
		.height_value (height_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int used_dim(logic [6:0] v);
		if (v == 7'd0)
			return 1;
		if (v > 7'd64)
			return 64;
		return int'(v);
	endfunction

	function automatic int clamp_index(int v, int n);
		if (v < 0)
			return 0;
		if (v > n - 1)
			return n - 1;
		return v;
	endfunction

	function automatic int fetch_height(int c, int r);
		return int'($signed(height_mem[r * STORE_COLS + c]));
	endfunction

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned root, trial;
		root = 0;
		for (int b = 26; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= n)
				root = trial;
		end
		return root;
	endfunction

	function automatic logic [15:0] scale_component(longint d, longint unsigned len);
		longint unsigned mag, q;
		logic [15:0] res;
		mag = (d < 0) ? longint'(-d) : longint'(d);
		q = ((mag << 24) + len) / (len << 1);
		if (q > 32767)
			q = 32767;
		res = q[15:0];
		if (d < 0)
			res = -res;
		return res;
	endfunction

	function automatic normal_t predict_normal(int c, int r);
		int w, h, pc, pr;
		longint dx, dz;
		longint unsigned sum, len;
		normal_t res;
		w = used_dim(grid_w_cfg);
		h = used_dim(grid_h_cfg);
		pc = (c < w) ? c : w - 1;
		pr = (r < h) ? r : h - 1;
		dx = longint'(fetch_height(clamp_index(pc - 1, w), pr))
			- fetch_height(clamp_index(pc + 1, w), pr);
		dz = longint'(fetch_height(pc, clamp_index(pr - 1, h)))
			- fetch_height(pc, clamp_index(pr + 1, h));
		sum = dx * dx + dz * dz + 64'd262144;
		len = root_floor(sum << 16);
		if (len == 0)
			len = 1;
		res.nx = scale_component(dx, len);
		res.ny = 15'(scale_component(512, len));
		res.nz = scale_component(dz, len);
		return res;
	endfunction

	function automatic bit apply_load(int c, int r, logic [15:0] hv);
		if (c >= used_dim(grid_w_cfg) || r >= used_dim(grid_h_cfg))
			return 1'b0;
		height_mem[r * STORE_COLS + c] = hv;
		height_known[r * STORE_COLS + c] = 1'b1;
		return 1'b1;
	endfunction

	function automatic logic [15:0] random_height();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [6:0] random_dim();
		case ($urandom_range(0, 7))
			0: return 7'd1;
			1: return 7'd64;
			2: return 7'd0;
			3: return 7'h7F;
			4: return 7'($urandom_range(65, 127));
			5, 6: return 7'($urandom_range(2, 8));
			default: return 7'($urandom_range(1, 64));
		endcase
	endfunction

	// The valid line stays high across a burst; it drops only when the burst ends.
	task automatic send_item(hnu_pkg::op_t op, int c, int r, logic [15:0] hv);
		in_valid <= 1'b1;
		operation <= op;
		col <= 6'(c);
		row <= 6'(r);
		height_value <= hv;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (op == hnu_pkg::OP_NORMAL)
			pending_normals = {pending_normals, predict_normal(c, r)};
		else
			void'(apply_load(c, r, hv));
		items_sent++;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	// Loads any neighbor the request reads that holds no height yet, then sends the request.
	task automatic request_normal(int c, int r);
		int w, h, pc, pr;
		int nc [4];
		int nr [4];
		w = used_dim(grid_w_cfg);
		h = used_dim(grid_h_cfg);
		pc = (c < w) ? c : w - 1;
		pr = (r < h) ? r : h - 1;
		nc = '{clamp_index(pc - 1, w), clamp_index(pc + 1, w), pc, pc};
		nr = '{pr, pr, clamp_index(pr - 1, h), clamp_index(pr + 1, h)};
		for (int i = 0; i < 4; i++) begin
			if (!height_known[nr[i] * STORE_COLS + nc[i]])
				send_item(hnu_pkg::OP_LOAD, nc[i], nr[i], random_height());
		end
		send_item(hnu_pkg::OP_NORMAL, c, r, 16'($urandom));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_normals.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic set_grid(logic [6:0] w, logic [6:0] h);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= hnu_pkg::REG_GRID_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		grid_w_cfg = w;
		cfg_index <= hnu_pkg::REG_GRID_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		grid_h_cfg = h;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_extremes();
		send_item(hnu_pkg::OP_LOAD, 63, 63, 16'h7FFF);
		send_item(hnu_pkg::OP_LOAD, 62, 63, 16'h8000);
		send_item(hnu_pkg::OP_LOAD, 63, 62, 16'h7FFF);
		request_normal(63, 63);
		send_item(hnu_pkg::OP_LOAD, 0, 0, 16'h8000);
		send_item(hnu_pkg::OP_LOAD, 1, 0, 16'h7FFF);
		send_item(hnu_pkg::OP_LOAD, 0, 1, 16'h7FFF);
		request_normal(0, 0);
		send_item(hnu_pkg::OP_LOAD, 9, 10, 16'h1234);
		send_item(hnu_pkg::OP_LOAD, 11, 10, 16'h1234);
		send_item(hnu_pkg::OP_LOAD, 10, 9, 16'h1234);
		send_item(hnu_pkg::OP_LOAD, 10, 11, 16'h1234);
		request_normal(10, 10);
	endtask

	task automatic test_grid_clamping();
		set_grid(7'd3, 7'd2);
		request_normal(63, 63);
		set_grid(7'd2, 7'd2);
		send_item(hnu_pkg::OP_LOAD, 2, 1, 16'h5A5A);
		send_item(hnu_pkg::OP_LOAD, 0, 5, 16'hA5A5);
		request_normal(1, 0);
		set_grid(7'd3, 7'd2);
		request_normal(2, 1);
	endtask

	task automatic test_register_range();
		set_grid(7'd0, 7'h7F);
		request_normal(40, 0);
		request_normal(0, 63);
		set_grid(7'h7F, 7'd0);
		request_normal(63, 9);
	endtask

	task automatic test_random_traffic();
		int w, h, pick;
		while (items_sent < ITEM_TARGET) begin
			set_grid(random_dim(), random_dim());
			w = used_dim(grid_w_cfg);
			h = used_dim(grid_h_cfg);
			repeat ($urandom_range(120, 260)) begin
				if (items_sent >= ITEM_TARGET)
					break;
				pick = $urandom_range(0, 99);
				if (pick < 25)
					request_normal($urandom_range(0, 63), $urandom_range(0, 63));
				else if (pick < 45)
					request_normal($urandom_range(0, w - 1), $urandom_range(0, h - 1));
				else if (pick < 90)
					send_item(hnu_pkg::OP_LOAD, $urandom_range(0, w - 1),
						$urandom_range(0, h - 1), random_height());
				else
					send_item(hnu_pkg::OP_LOAD, $urandom_range(0, 63),
						$urandom_range(0, 63), random_height());
			end
		end
	endtask

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 300);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_OPEN: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		normal_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_normals.size() == 0) begin
				$display("%0t: result with none expected, actual x=%0d y=%0d z=%0d",
					$time, normal_x, normal_y, normal_z);
				mismatches++;
			end else begin
				want = pending_normals.pop_front();
				if (normal_x !== want.nx) begin
					$display("%0t: normal_x expected %0d actual %0d", $time, want.nx, normal_x);
					mismatches++;
				end
				if (normal_y !== want.ny) begin
					$display("%0t: normal_y expected %0d actual %0d", $time, want.ny, normal_y);
					mismatches++;
				end
				if (normal_z !== want.nz) begin
					$display("%0t: normal_z expected %0d actual %0d", $time, want.nz, normal_z);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run timed out", $time);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= hnu_pkg::OP_LOAD;
		col <= 6'd0;
		row <= 6'd0;
		height_value <= 16'sd0;
		cfg_valid <= 1'b0;
		cfg_index <= hnu_pkg::REG_GRID_WIDTH;
		cfg_data <= 7'd0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_grid_clamping();
		test_register_range();
		test_random_traffic();
		settle();
		if (mismatches == 0 && pending_normals.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
